// ===== rtl/core/sal_pkg.sv =====
// shared types and constants for the shifting array list
// no dependencies; used by the interfaces, the element cell and the top level

package sal_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 6;
  localparam int unsigned OutW   = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_EDIT   = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_FIND   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_IDX  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // found_position when nothing matched or the word was not a find
  localparam logic [OutW-1:0] FoundNone = {OutW{1'b1}};

  // broadcast control from the top level to every cell
  typedef struct packed {
    mode_e mode;
    logic  apply;       // checked update, applied this cycle
    logic  find_load;   // capture compare result into the match flags
    logic  scan_shift;  // move the match flags one cell towards the head
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sal_if.sv =====
// request and response channel interfaces of the shifting array list
// depends on sal_pkg for the field widths

interface sal_req_if;
  import sal_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface sal_rsp_if;
  import sal_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic signed [OutW-1:0] found_position;
  logic [OutW-1:0]        count;

  modport source (output valid, status, found_position, count, input ready);
  modport sink   (input valid, status, found_position, count, output ready);
endinterface

// ===== rtl/core/shifting_array_list.sv =====
// top level of the shifting array list: control, element count and result register
// depends on sal_pkg, sal_req_if / sal_rsp_if and sal_cell

// A packed ordered list of signed 32-bit values, one per cell of a row of
// CAPACITY cells. Requests arrive on req_i (valid/ready), one word per
// operation: append, insert, edit, delete or find. Every request gives one
// response word on rsp_o with a status, the found position and the count.
// Append, insert, edit and delete update the cells in the accepting cycle:
// each cell loads the new value, its left neighbour (insert) or its right
// neighbour (delete). Their response is valid the cycle after acceptance,
// so with a ready receiver one such word is taken every cycle.
// Find compares every cell against the key in the accepting cycle and
// registers a match flag per cell; the flags then shift towards cell 0 one
// place a cycle until a match reaches the head or the list is exhausted.
// A find hit answers with the matching position, a miss with all ones in
// found_position, once the scan has ended; no request is taken meanwhile.
// The response register decouples the sides: a new word is taken while a
// response is still waiting if the receiver takes it in the same cycle.
// When the receiver stalls, the response holds and requests stall.
// Reset empties the list (count zero) and drops any pending response;
// cell contents are not cleared, entries at or above count are never read.

module shifting_array_list import sal_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sal_req_if.sink     req_i,
  sal_rsp_if.source   rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  // compare width wide enough for both the position field and the count
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // list state
  logic [CntW-1:0] count_q, count_d;

  // find scan
  logic            scan_q, scan_d;
  logic [IdxW-1:0] scan_cnt_q, scan_cnt_d;
  logic            scan_done;
  logic            head_match;

  // response register
  logic            rsp_valid_q, rsp_valid_d;
  status_e         rsp_status_q, rsp_status_d;
  logic [OutW-1:0] rsp_found_q, rsp_found_d;
  logic [OutW-1:0] rsp_count_q, rsp_count_d;

  // request decode
  logic            req_acc;
  mode_e           req_mode;
  logic [CmpW-1:0] pos_cmp;
  logic [CmpW-1:0] count_cmp;
  logic            idx_ok;
  logic            list_full;
  status_e         req_status;
  logic            is_update;

  cell_ctrl_t        cell_ctrl;
  logic [ValueW-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  // no new word during a find scan, and only when the response slot frees
  assign req_i.ready = !scan_q && (!rsp_valid_q || rsp_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;
  assign req_mode    = mode_e'(req_i.mode);

  assign pos_cmp   = CmpW'(req_i.position);
  assign count_cmp = CmpW'(count_q);
  assign idx_ok    = pos_cmp < count_cmp;
  assign list_full = count_q == CapCnt;

  always_comb begin
    req_status = ST_OK;
    is_update  = 1'b0;
    case (req_mode)
      MODE_APPEND: begin
        is_update = 1'b1;
        if (list_full) req_status = ST_FULL;
      end
      MODE_INSERT: begin
        is_update = 1'b1;
        if (!idx_ok) req_status = ST_IDX;
        else if (list_full) req_status = ST_FULL;
      end
      MODE_EDIT, MODE_DELETE: begin
        is_update = 1'b1;
        if (!idx_ok) req_status = ST_IDX;
      end
      default: ;
    endcase
  end

  always_comb begin
    cell_ctrl.mode       = req_mode;
    cell_ctrl.apply      = req_acc && is_update && (req_status == ST_OK);
    cell_ctrl.find_load  = req_acc && (req_mode == MODE_FIND);
    cell_ctrl.scan_shift = scan_q && !scan_done;
  end

  always_comb begin
    count_d = count_q;
    if (cell_ctrl.apply) begin
      case (req_mode)
        MODE_APPEND, MODE_INSERT: count_d = count_q + CntW'(1);
        MODE_DELETE:              count_d = count_q - CntW'(1);
        default: ;
      endcase
    end
  end

  // row of cells, each passing data to both neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0] left_w;
    logic [ValueW-1:0] right_w;
    logic              match_right_w;

    if (i == 0) begin : g_head
      assign left_w = req_i.value;
    end else begin : g_body
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w       = cell_data[i];
      assign match_right_w = 1'b0;
    end else begin : g_inner
      assign right_w       = cell_data[i+1];
      assign match_right_w = cell_match[i+1];
    end

    sal_cell #(
      .CmpW (CmpW),
      .Idx  (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .pos_i         (pos_cmp),
      .count_i       (count_cmp),
      .value_i       (req_i.value),
      .left_i        (left_w),
      .right_i       (right_w),
      .match_right_i (match_right_w),
      .data_o        (cell_data[i]),
      .match_o       (cell_match[i])
    );
  end

  // scan: the flag at cell 0 stands for position scan_cnt_q
  assign head_match = cell_match[0];
  assign scan_done  = scan_q &&
                      (head_match || ((CntW'(scan_cnt_q) + CntW'(1)) >= count_q));

  always_comb begin
    scan_d     = scan_q;
    scan_cnt_d = scan_cnt_q;
    if (cell_ctrl.find_load) begin
      scan_d     = 1'b1;
      scan_cnt_d = '0;
    end else if (scan_done) begin
      scan_d = 1'b0;
    end else if (scan_q) begin
      scan_cnt_d = scan_cnt_q + IdxW'(1);
    end
  end

  // response register
  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_found_d  = rsp_found_q;
    rsp_count_d  = rsp_count_q;
    if (rsp_o.ready) rsp_valid_d = 1'b0;
    if (req_acc && (req_mode != MODE_FIND)) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = req_status;
      rsp_found_d  = FoundNone;
      rsp_count_d  = OutW'(count_d);
    end else if (scan_done) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = ST_OK;
      rsp_found_d  = head_match ? OutW'(scan_cnt_q) : FoundNone;
      rsp_count_d  = OutW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= 1'b0;
      scan_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_q      <= scan_d;
      scan_cnt_q  <= scan_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_status_q <= rsp_status_d;
    rsp_found_q  <= rsp_found_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.found_position = rsp_found_q;
  assign rsp_o.count          = rsp_count_q;

  // no response is pending while a find scan runs
  a_scan_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q |-> !rsp_valid_q)
    else $error("response pending during find scan");

  // the list never grows beyond its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("element count above capacity");

  // an accepted find always starts a scan
  a_find_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_mode == MODE_FIND)) |=> scan_q)
    else $error("find accepted without scan");

  // an unfinished scan advances exactly one position
  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q && !scan_done) |=> (scan_q && (scan_cnt_q == $past(scan_cnt_q) + IdxW'(1))))
    else $error("find scan did not advance");

endmodule

// ===== rtl/core/sal_cell.sv =====
// one element cell of the list: holds a value and a match flag
// depends on sal_pkg; neighbours hand data in from both sides

module sal_cell import sal_pkg::*; #(
  parameter int unsigned CmpW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CmpW-1:0]   pos_i,
  input  logic [CmpW-1:0]   count_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [ValueW-1:0] left_i,
  input  logic [ValueW-1:0] right_i,
  input  logic              match_right_i,
  output logic [ValueW-1:0] data_o,
  output logic              match_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic [ValueW-1:0] data_q, data_d;
  logic              match_q, match_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.apply) begin
      case (ctrl_i.mode)
        MODE_APPEND: begin
          if (MyIdx == count_i) data_d = value_i;
        end
        MODE_INSERT: begin
          if (MyIdx == pos_i) data_d = value_i;
          else if (MyIdx > pos_i) data_d = left_i;
        end
        MODE_EDIT: begin
          if (MyIdx == pos_i) data_d = value_i;
        end
        MODE_DELETE: begin
          if (MyIdx >= pos_i) data_d = right_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.find_load) begin
      match_d = (data_q == value_i) && (MyIdx < count_i);
    end else if (ctrl_i.scan_shift) begin
      match_d = match_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ===== verif/shifting_array_list_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the shifting array list: directed words, then phased random traffic
// depends on sal_pkg, sal_req_if / sal_rsp_if and the shifting_array_list rtl

module shifting_array_list_tb;
  import sal_pkg::*;

  localparam int unsigned ListDepth     = 64;
  localparam int unsigned IdlePct       = 28;      // chance of an idle cycle on either side
  localparam int unsigned RandomWords   = 930;
  localparam int unsigned RspHoldCycles = 220;     // long receiver hold-off, fills the block
  localparam int unsigned DrainCycles   = 8;       // settle time after the last response
  localparam longint      RunLimitNs    = 10_000_000;

  // modes the block treats as no-ops
  localparam logic [ModeW-1:0] ModeSpareFirst = 3'd5;
  localparam logic [ModeW-1:0] ModeSpareMid   = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareLast  = 3'd7;

  typedef enum {BIAS_FILL, BIAS_MIX, BIAS_DRAIN} bias_e;

  // shadow copy of the list plus the queue of responses still owed by the block
  class list_scoreboard #(int unsigned DEPTH = 64);
    typedef struct packed {
      logic [1:0]      status;
      logic [OutW-1:0] found;
      logic [OutW-1:0] count;
    } outcome_t;

    logic signed [ValueW-1:0] slots [DEPTH];
    int unsigned              used;
    outcome_t                 due [$];
    int unsigned              failures;

    function new();
      used     = 0;
      failures = 0;
    endfunction

    // apply an accepted request to the shadow list and queue its response
    function void note_request(logic [ModeW-1:0] mode, logic [PosW-1:0] pos,
                               logic signed [ValueW-1:0] val);
      outcome_t o;
      int       hit;
      int       i;
      o.status = ST_OK;
      hit      = -1;
      case (mode)
        MODE_APPEND: begin
          if (used >= DEPTH) o.status = ST_FULL;
          else begin
            slots[used] = val;
            used++;
          end
        end
        MODE_INSERT: begin
          // index check ranks above the full check
          if (pos >= used) o.status = ST_IDX;
          else if (used >= DEPTH) o.status = ST_FULL;
          else begin
            for (i = used; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = val;
            used++;
          end
        end
        MODE_EDIT: begin
          if (pos >= used) o.status = ST_IDX;
          else slots[pos] = val;
        end
        MODE_DELETE: begin
          if (pos >= used) o.status = ST_IDX;
          else begin
            for (i = pos; i + 1 < used; i++) slots[i] = slots[i+1];
            used--;
          end
        end
        MODE_FIND: begin
          for (i = 0; i < used; i++) begin
            if (slots[i] == val) begin
              hit = i;
              break;
            end
          end
        end
        default: ;
      endcase
      o.found = hit[OutW-1:0];
      o.count = used[OutW-1:0];
      due.push_back(o);
    endfunction

    // compare one accepted response with the oldest outstanding one
    function void check_response(logic [1:0] status, logic [OutW-1:0] found,
                                 logic [OutW-1:0] count);
      outcome_t want;
      if (due.size() == 0) begin
        $error("unexpected response word: status %0d found_position %0d count %0d",
               status, $signed(found), count);
        failures++;
        return;
      end
      want = due.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        failures++;
      end
      if (found !== want.found) begin
        $error("found_position: expected %0d, got %0d", $signed(want.found), $signed(found));
        failures++;
      end
      if (count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, count);
        failures++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sal_req_if req ();
  sal_rsp_if rsp ();

  list_scoreboard #(ListDepth) sb;

  // both sides stop idling while this is set
  bit calm      = 1'b0;
  // request from the sender side for one long receiver hold-off
  bit hold_rsp  = 1'b0;

  shifting_array_list #(
    .CAPACITY(ListDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  // offer one word, with random idle cycles in front of it, and record it
  // in the shadow list at the edge where the block takes it
  task automatic send_word(input logic [ModeW-1:0] mode, input logic [PosW-1:0] pos,
                           input logic signed [ValueW-1:0] val);
    if (!calm && $urandom_range(99) < IdlePct) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < IdlePct);
    end
    req.valid    <= 1'b1;
    req.mode     <= mode;
    req.position <= pos;
    req.value    <= val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(mode, pos, val);
  endtask

  // stop offering and wait until every response owed has come back
  task automatic wait_all_answered();
    req.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  // mode mix depends on the phase: fill pushes the list towards full,
  // drain empties it, mix churns around the middle
  function automatic logic [ModeW-1:0] pick_mode(bias_e bias);
    int cut [5];
    int r;
    case (bias)
      BIAS_FILL:  cut = '{50, 70, 78, 86, 96};
      BIAS_DRAIN: cut = '{8, 18, 28, 80, 96};
      default:    cut = '{22, 40, 55, 77, 96};
    endcase
    r = $urandom_range(99);
    if (r < cut[0]) return MODE_APPEND;
    if (r < cut[1]) return MODE_INSERT;
    if (r < cut[2]) return MODE_EDIT;
    if (r < cut[3]) return MODE_DELETE;
    if (r < cut[4]) return MODE_FIND;
    return ModeW'($urandom_range(ModeSpareLast, ModeSpareFirst));
  endfunction

  // mostly occupied slots, some right at the end of the list, some anywhere
  function automatic logic [PosW-1:0] pick_position();
    int r;
    r = $urandom_range(99);
    if (sb.used != 0 && r < 72) return PosW'($urandom_range(sb.used - 1, 0));
    if (r < 84) return sb.used[PosW-1:0];
    return PosW'($urandom_range((1 << PosW) - 1, 0));
  endfunction

  // stored values give find hits and duplicate entries; small values
  // repeat often; the rest is full-width noise
  function automatic logic signed [ValueW-1:0] pick_value(logic [ModeW-1:0] mode);
    int r;
    int keep;
    r    = $urandom_range(99);
    keep = (mode == MODE_FIND) ? 60 : 30;
    if (sb.used != 0 && r < keep) return sb.slots[$urandom_range(sb.used - 1, 0)];
    if (r < keep + 15) return $signed($urandom_range(3, 0)) - 2;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : request_side
    logic [ModeW-1:0]         mode;
    logic [PosW-1:0]          pos;
    logic signed [ValueW-1:0] val;
    bias_e                    bias;
    int                       sent;
    int                       round;
    int                       span;

    sb           = new();
    req.valid    = 1'b0;
    req.mode     = MODE_APPEND;
    req.position = '0;
    req.value    = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: empty list corner cases first
    send_word(MODE_FIND,   6'd0,  32'sd0);                 // find on empty list misses
    send_word(MODE_DELETE, 6'd0,  32'sd0);                 // delete from empty list
    send_word(MODE_EDIT,   6'd63, 32'sd0);                 // edit beyond the end
    send_word(MODE_INSERT, 6'd0,  32'sd0);                 // insert at count is refused
    // value extremes, with a duplicate to check lowest-index search
    send_word(MODE_APPEND, 6'd0,  32'sh8000_0000);
    send_word(MODE_APPEND, 6'd63, 32'sh7FFF_FFFF);
    send_word(MODE_APPEND, 6'd0,  32'sd0);
    send_word(MODE_APPEND, 6'd0,  -32'sd1);
    send_word(MODE_APPEND, 6'd0,  32'sh7FFF_FFFF);
    send_word(MODE_FIND,   6'd63, 32'sh7FFF_FFFF);
    // insert at the head and at the last occupied slot, then just past it
    send_word(MODE_INSERT, 6'd0,  32'sh5555_5555);
    send_word(MODE_INSERT, 6'd5,  32'shAAAA_AAAA);
    send_word(MODE_INSERT, 6'd7,  32'sd1);
    send_word(MODE_EDIT,   6'd0,  32'sh1234_5678);
    send_word(MODE_EDIT,   6'd63, 32'sd1);
    // delete head, delete tail, delete out of range
    send_word(MODE_DELETE, 6'd0,  32'sd0);
    send_word(MODE_DELETE, 6'd5,  32'sd0);
    send_word(MODE_DELETE, 6'd63, 32'sd0);
    send_word(MODE_FIND,   6'd0,  32'shDEAD_BEEF);         // absent value
    send_word(MODE_FIND,   6'd0,  -32'sd1);
    send_word(MODE_FIND,   6'd0,  32'sh8000_0000);
    // spare modes are no-ops
    send_word(ModeSpareFirst, 6'd63, -32'sd1);
    send_word(ModeSpareMid,   6'd0,  32'sd0);
    send_word(ModeSpareLast,  6'd63, 32'sh7FFF_FFFF);

    // random part in phases; the fill phase hits the full store, the drain
    // phase empties it again
    sent  = 0;
    round = 0;
    while (sent < RandomWords) begin
      case (round % 4)
        0:       bias = BIAS_FILL;
        2:       bias = BIAS_DRAIN;
        default: bias = BIAS_MIX;
      endcase
      span = (bias == BIAS_MIX) ? $urandom_range(90, 50) : $urandom_range(170, 130);
      // last phase stops at the word budget
      if (span > int'(RandomWords) - sent) span = int'(RandomWords) - sent;
      // sender pauses until the block has answered everything
      if (bias == BIAS_DRAIN) wait_all_answered();
      // one stretch with no idling on either side
      calm = (round == 3);
      repeat (span) begin
        // receiver holds off once while we keep offering
        if (sent == 40) hold_rsp = 1'b1;
        mode = pick_mode(bias);
        pos  = pick_position();
        val  = pick_value(mode);
        send_word(mode, pos, val);
        sent++;
      end
      round++;
    end
    calm = 1'b0;

    wait_all_answered();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response side: random back-pressure, one long hold-off, checking
  // ---------------------------------------------------------------------------
  initial begin : response_side
    int hold_left;
    hold_left = 0;
    rsp.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        sb.check_response(rsp.status, rsp.found_position, rsp.count);
      end
      if (hold_rsp && hold_left == 0) begin
        hold_left = RspHoldCycles;
        hold_rsp  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (calm) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // hang guard
  initial begin : watchdog
    #(RunLimitNs);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sal_pkg.sv
rtl/core/sal_if.sv
rtl/core/sal_cell.sv
rtl/core/shifting_array_list.sv
verif/shifting_array_list_tb.sv
